// File: hdl/pbdp_pkg.sv
// ----------------------------------------------------------------------------
// pbdp_pkg
// Constants and types shared by the palette dither packer: luma weights, Bayer matrix.
// ----------------------------------------------------------------------------
package pbdp_pkg;

  localparam int unsigned LumaW = 16;

  localparam logic [LumaW-1:0] LumaWeightR = 16'd77;
  localparam logic [LumaW-1:0] LumaWeightG = 16'd150;
  localparam logic [LumaW-1:0] LumaWeightB = 16'd29;

  localparam logic [3:0] Bayer4 [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6 },
    '{4'd3,  4'd11, 4'd1,  4'd9 },
    '{4'd15, 4'd7,  4'd13, 4'd5 }
  };

  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_PIXEL   = 1'b1
  } op_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] scanline;
    logic       draw;
  } pix_ctl_t;

endpackage

// File: hdl/palette_bayer_dither_packer.sv
// ----------------------------------------------------------------------------
// palette_bayer_dither_packer
// Palette luma lookup, 4x4 Bayer ordered dither, 8-to-1 bit packing.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// cfg       row_phase_offset_we_i     row_phase_offset_i
// in        in_valid_i / in_ready_o   op, index, red, green, blue, scanline, draw
// out       out_valid_o / out_ready_i out_byte, byte_column, row, line_end
//
// One item per cycle unless the output stalls. A byte reaches its output
// register after the pixel that completes it is accepted and passes through the
// input reg, the luma RAM read and dither/pack into the output register. Reset
// clears the luma valid bits at once; no clearing pass. A stalled output holds
// only the stages behind it that need it; pixels that emit nothing keep flowing.
// ----------------------------------------------------------------------------
module palette_bayer_dither_packer #(
  parameter int unsigned LINE_WIDTH   = 256,
  parameter int unsigned LINE_COUNT   = 240,
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       row_phase_offset_we_i,
  input  logic [1:0] row_phase_offset_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] index_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] scanline_i,
  input  logic       draw_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [4:0] byte_column_o,
  output logic [7:0] row_o,
  output logic       line_end_o
);
  import pbdp_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_SIZE);
  localparam int unsigned PW = $clog2(LINE_WIDTH);
  localparam logic [8:0]    PalSize   = 9'(PALETTE_SIZE);
  localparam logic [10:0]   LineCount = 11'(LINE_COUNT);
  localparam logic [PW-1:0] LastPos   = PW'(LINE_WIDTH - 1);
  localparam logic [4:0]    LastCol   = 5'((LINE_WIDTH - 1) / 8);

  logic [1:0] offset_q;

  // stage 1: input register
  logic       s1_valid_q;
  op_e        s1_op_q;
  logic [7:0] s1_index_q, s1_red_q, s1_green_q, s1_blue_q;
  pix_ctl_t   s1_ctl_q;

  // stage 2: luma read
  logic       s2_valid_q;
  pix_ctl_t   s2_ctl_q;
  logic       s2_hit_q;
  logic [7:0] s2_rd_q;

  // luma table
  logic [7:0]        mem [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] lv_q;

  logic [7:0]    acc_q;
  logic [PW-1:0] pos_q;

  logic       out_valid_q, line_end_q;
  logic [7:0] out_byte_q, row_q;
  logic [4:0] byte_col_q;

  logic              out_ok, s2_fire, s2_free, s1_fire, s1_free;
  logic              s1_in_range, s1_hit, s1_wr;
  logic [AW-1:0]     s1_addr;
  logic [LumaW-1:0]  luma_sum;
  logic [7:0]        luma_new, s2_luma, threshold, bit_mask, acc_new;
  logic [1:0]        dither_row;
  logic              white, last, done, s2_emit;
  logic [12:0]       col_ext;

  assign out_ok  = !out_valid_q || out_ready_i;
  assign s2_fire = s2_valid_q && (!s2_emit || out_ok);
  assign s2_free = !s2_valid_q || s2_fire;
  assign s1_fire = s1_valid_q && s2_free;
  assign s1_free = !s1_valid_q || s1_fire;
  assign in_ready_o = s1_free;

  assign s1_in_range = {1'b0, s1_index_q} < PalSize;
  assign s1_addr     = s1_index_q[AW-1:0];
  assign s1_hit      = s1_in_range && lv_q[s1_addr];
  assign s1_wr       = s1_fire && (s1_op_q == OP_PALETTE) && s1_in_range;

  assign luma_sum = 16'(s1_red_q) * LumaWeightR + 16'(s1_green_q) * LumaWeightG
                  + 16'(s1_blue_q) * LumaWeightB;
  assign luma_new = luma_sum[15:8];

  assign s2_luma    = s2_hit_q ? s2_rd_q : 8'd0;
  assign dither_row = s2_ctl_q.scanline[1:0] + offset_q;
  assign threshold  = {Bayer4[dither_row][pos_q[1:0]], 4'b1000};
  assign white      = s2_luma >= threshold;
  assign bit_mask   = 8'h80 >> pos_q[2:0];
  assign acc_new    = white ? (acc_q | bit_mask) : acc_q;
  assign last       = pos_q == LastPos;
  assign done       = (pos_q[2:0] == 3'd7) || last;
  assign s2_emit    = done && s2_ctl_q.draw && ({3'b000, s2_ctl_q.scanline} < LineCount);
  assign col_ext    = 13'(pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= 2'd0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      lv_q        <= '0;
      acc_q       <= 8'd0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (row_phase_offset_we_i) begin
        offset_q <= row_phase_offset_i;
      end
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_fire && (s1_op_q == OP_PIXEL);
      end
      if (s1_wr) begin
        lv_q[s1_addr] <= 1'b1;
      end
      if (s2_fire) begin
        acc_q <= done ? 8'd0 : acc_new;
        pos_q <= last ? '0 : pos_q + 1'b1;
      end
      if (s2_fire && s2_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_free) begin
      s1_op_q        <= op_e'(op_i);
      s1_index_q     <= index_i;
      s1_red_q       <= red_i;
      s1_green_q     <= green_i;
      s1_blue_q      <= blue_i;
      s1_ctl_q       <= '{valid: 1'b1, scanline: scanline_i, draw: draw_i};
    end
    if (s1_fire) begin
      s2_ctl_q <= s1_ctl_q;
      s2_hit_q <= s1_hit;
    end
    if (s2_fire && s2_emit) begin
      out_byte_q <= acc_new;
      byte_col_q <= col_ext[7:3];
      row_q      <= s2_ctl_q.scanline;
      line_end_q <= last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      mem[s1_addr] <= luma_new;
    end
    if (s1_fire) begin
      s2_rd_q <= mem[s1_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_column_o = byte_col_q;
  assign row_o         = row_q;
  assign line_end_o    = line_end_q;

`ifndef NO_ASSERTIONS
  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("pixel position past line end");

  a_acc_clear_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q & (8'hFF >> pos_q[2:0])) == 8'd0)
    else $error("accumulator has bits at or after current position");

  a_line_end_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && line_end_q |-> byte_col_q == LastCol)
    else $error("line end on wrong byte column");

  a_oor_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_in_range |=> !s2_hit_q)
    else $error("out-of-range palette index hit the table");
`endif

endmodule
